/* src/oems_pkg.sv */
// ----------------------------------------------------------------------------
// oems_pkg: shared types and constants
// Widths, register map codes and controller/datapath handshake structs for the
// odd-even merge comparator schedule generator.
// ----------------------------------------------------------------------------
`default_nettype none

package oems_pkg;

	// Largest supported log2 of the network size
	localparam int MAX_LOG2_INPUTS = 10;

	// Configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int CFG_W  = 4;
	localparam logic [CFG_W-1:0] LOG2_INPUTS_RESET = 4'd3;

	// Register indexes (paddr[2])
	localparam logic REG_LOG2_INPUTS = 1'b0;

	// Result field widths
	localparam int LEVEL_W = 6;
	localparam int CHAN_W  = 10;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;      // request transfer this cycle
		logic start_over;  // rewind before emitting (valid with accept)
		logic step;        // advance the walk by one candidate
		logic load_out;    // move the held comparator into the output register
		logic cfg_rewind;  // register write: rewind the walk
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_comp;     // current walk position is a real comparator
	} sts_t;

endpackage

`default_nettype wire

/* src/oems_if.sv */
// ----------------------------------------------------------------------------
// oems_if: request and comparator channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface oems_req_if;
	logic valid;
	logic ready;
	logic start_over;

	modport source (output valid, output start_over, input ready);
	modport sink   (input valid, input start_over, output ready);
endinterface

interface oems_cmp_if;
	logic                         valid;
	logic                         ready;
	logic [oems_pkg::LEVEL_W-1:0] level;
	logic [oems_pkg::CHAN_W-1:0]  low_channel;
	logic [oems_pkg::CHAN_W-1:0]  high_channel;
	logic                         last_comparator;

	modport source (output valid, output level, output low_channel, output high_channel,
		output last_comparator, input ready);
	modport sink   (input valid, input level, input low_channel, input high_channel,
		input last_comparator, output ready);
endinterface

`default_nettype wire

/* src/odd_even_merge_comparator_schedule.sv */
// ----------------------------------------------------------------------------
// odd_even_merge_comparator_schedule: odd-even merge network schedule
// Each request returns the next comparator (level, min channel, max channel,
// last flag) of the odd-even merge sorting network for 2^log2_inputs inputs.
//
//   channel  dir  carries
//   req      in   start_over
//   cmp      out  level, low_channel, high_channel, last_comparator
//   apb      in   log2_inputs at byte address 0
//
// After a request transfers, the walk visits one candidate pair per cycle until
// it reaches the following comparator, skipping pairs that the same-block test
// rejects; the held result then waits for a free output register.
// Each step is made by the single advance unit in the datapath.
// Reset rewinds the walk to the first comparator; so does any register write.
// A stalled result sits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_merge_comparator_schedule #(
	parameter int MAX_LOG2_INPUTS = oems_pkg::MAX_LOG2_INPUTS,
	localparam int LW = $clog2(MAX_LOG2_INPUTS + 2)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [oems_pkg::ADDR_W-1:0] paddr,
	input  wire logic [oems_pkg::DATA_W-1:0] pwdata,
	output logic      [oems_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	oems_req_if.sink                         req,
	oems_cmp_if.source                       cmp
);

	logic [LW-1:0]   eff_log2;
	logic            cfg_rewind;
	oems_pkg::cmd_t  cmd;
	oems_pkg::sts_t  sts;

	oems_regs #(.MAX_LOG2_INPUTS(MAX_LOG2_INPUTS)) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.eff_log2   (eff_log2),
		.cfg_rewind (cfg_rewind)
	);

	oems_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (req.valid),
		.in_start_over (req.start_over),
		.in_ready      (req.ready),
		.out_valid     (cmp.valid),
		.out_ready     (cmp.ready),
		.cfg_rewind    (cfg_rewind),
		.sts           (sts),
		.cmd           (cmd)
	);

	oems_dp #(.MAX_LOG2_INPUTS(MAX_LOG2_INPUTS)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.eff_log2        (eff_log2),
		.cmd             (cmd),
		.sts             (sts),
		.level           (cmp.level),
		.low_channel     (cmp.low_channel),
		.high_channel    (cmp.high_channel),
		.last_comparator (cmp.last_comparator)
	);

endmodule

`default_nettype wire

/* src/oems_regs.sv */
// ----------------------------------------------------------------------------
// oems_regs: configuration register block
// APB-style slave holding log2_inputs; gives the clamped network size and a
// rewind pulse on every write to the register.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_regs #(
	parameter int MAX_LOG2_INPUTS = oems_pkg::MAX_LOG2_INPUTS,
	localparam int LW = $clog2(MAX_LOG2_INPUTS + 2)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [oems_pkg::ADDR_W-1:0] paddr,
	input  wire logic [oems_pkg::DATA_W-1:0] pwdata,
	output logic      [oems_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	output logic      [LW-1:0]               eff_log2,
	output logic                             cfg_rewind
);

	logic [oems_pkg::CFG_W-1:0] log2_inputs_q;
	logic                       wr_hit;

	// Write decode: register index sits in paddr[2]
	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr[2] == oems_pkg::REG_LOG2_INPUTS);
	assign cfg_rewind = wr_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_inputs_q <= oems_pkg::LOG2_INPUTS_RESET;
		end else if (wr_hit) begin
			log2_inputs_q <= pwdata[oems_pkg::CFG_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (paddr[2] == oems_pkg::REG_LOG2_INPUTS) begin
			prdata = oems_pkg::DATA_W'(log2_inputs_q);
		end
	end

	// Clamp to 1..MAX_LOG2_INPUTS
	always_comb begin
		if (log2_inputs_q == '0) begin
			eff_log2 = LW'(1);
		end else if (int'(log2_inputs_q) > MAX_LOG2_INPUTS) begin
			eff_log2 = LW'(MAX_LOG2_INPUTS);
		end else begin
			eff_log2 = LW'(log2_inputs_q);
		end
	end

endmodule

`default_nettype wire

/* src/oems_ctrl.sv */
// ----------------------------------------------------------------------------
// oems_ctrl: sequencing controller
// Takes a request, lets the datapath seek the next comparator one candidate
// per cycle, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_start_over,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire logic          cfg_rewind,
	input  oems_pkg::sts_t     sts,
	output oems_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEEK = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.cfg_rewind = cfg_rewind;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept     = 1'b1;
					cmd.start_over = in_start_over;
					state_d        = ST_SEEK;
				end
			end
			ST_SEEK: begin
				if (!sts.is_comp) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* src/oems_dp.sv */
// ----------------------------------------------------------------------------
// oems_dp: walk datapath
// Holds the nested loop position (round, stride, block, channel, level), the
// advance logic for one candidate per cycle, and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_dp #(
	parameter int MAX_LOG2_INPUTS = oems_pkg::MAX_LOG2_INPUTS,
	localparam int LW = $clog2(MAX_LOG2_INPUTS + 2),
	localparam int CW = MAX_LOG2_INPUTS + 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [LW-1:0]                eff_log2,
	input  oems_pkg::cmd_t                    cmd,
	output oems_pkg::sts_t                    sts,
	output logic      [oems_pkg::LEVEL_W-1:0] level,
	output logic      [oems_pkg::CHAN_W-1:0]  low_channel,
	output logic      [oems_pkg::CHAN_W-1:0]  high_channel,
	output logic                              last_comparator
);

	// Walk position
	logic [LW-1:0]                round_q;
	logic [CW-1:0]                stride_q, block_q, pos_q;
	logic [oems_pkg::LEVEL_W-1:0] level_q;
	logic                         wrapped_q;

	// Comparator held until the output register is free
	logic [oems_pkg::LEVEL_W-1:0] hold_level_q;
	logic [oems_pkg::CHAN_W-1:0]  hold_low_q, hold_high_q;

	// Output register
	logic [oems_pkg::LEVEL_W-1:0] out_level_q;
	logic [oems_pkg::CHAN_W-1:0]  out_low_q, out_high_q;
	logic                         out_last_q;

	// Base position and advanced position
	logic [LW-1:0]                b_round, n_round, r1;
	logic [CW-1:0]                b_stride, b_block, b_pos;
	logic [CW-1:0]                n_stride, n_block, n_pos;
	logic [oems_pkg::LEVEL_W-1:0] b_level, n_level;
	logic [CW-1:0]                n_size, top, jk, upper, m1, k2, j2, b_hi, cur_hi;
	logic                         adv_wrap;

	// Base: a start-over request walks from the first comparator
	always_comb begin
		if (cmd.accept && cmd.start_over) begin
			b_round  = LW'(1);
			b_stride = CW'(1);
			b_block  = '0;
			b_pos    = '0;
			b_level  = '0;
		end else begin
			b_round  = round_q;
			b_stride = stride_q;
			b_block  = block_q;
			b_pos    = pos_q;
			b_level  = level_q;
		end
		b_hi = b_pos + b_stride;
	end

	// One step of the nested loops
	always_comb begin
		n_size = CW'(1) << eff_log2;
		top    = n_size - b_stride;
		jk     = b_stride + b_block;
		upper  = (jk < top) ? jk : top;
		m1     = b_pos + CW'(1);
		k2     = b_block + (b_stride << 1);
		j2     = b_stride >> 1;
		r1     = b_round + LW'(1);

		n_round  = b_round;
		n_stride = b_stride;
		n_block  = b_block;
		n_pos    = b_pos;
		n_level  = b_level;
		adv_wrap = 1'b0;

		if (m1 < upper) begin
			n_pos = m1;
		end else if (k2 < top) begin
			n_block = k2;
			n_pos   = k2;
		end else if (j2 != '0) begin
			// next stride inside the same round
			n_level  = b_level + oems_pkg::LEVEL_W'(1);
			n_stride = j2;
			n_block  = j2;
			n_pos    = j2;
		end else if (r1 <= eff_log2) begin
			// next merge round starts with stride 2^(round-1)
			n_level  = b_level + oems_pkg::LEVEL_W'(1);
			n_round  = r1;
			n_stride = CW'(1) << b_round;
			n_block  = '0;
			n_pos    = '0;
		end else begin
			// past the final comparator: wrap to the first
			n_round  = LW'(1);
			n_stride = CW'(1);
			n_block  = '0;
			n_pos    = '0;
			n_level  = '0;
			adv_wrap = 1'b1;
		end
	end

	// Same-block test on the current position
	assign cur_hi      = pos_q + stride_q;
	assign sts.is_comp = ((pos_q >> round_q) == (cur_hi >> round_q));

	// Walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q   <= LW'(1);
			stride_q  <= CW'(1);
			block_q   <= '0;
			pos_q     <= '0;
			level_q   <= '0;
			wrapped_q <= 1'b0;
		end else if (cmd.cfg_rewind) begin
			round_q  <= LW'(1);
			stride_q <= CW'(1);
			block_q  <= '0;
			pos_q    <= '0;
			level_q  <= '0;
		end else if (cmd.accept || cmd.step) begin
			round_q   <= n_round;
			stride_q  <= n_stride;
			block_q   <= n_block;
			pos_q     <= n_pos;
			level_q   <= n_level;
			wrapped_q <= cmd.accept ? adv_wrap : (wrapped_q || adv_wrap);
		end
	end

	// Capture the emitted comparator on request transfer; move it to the output register on load_out
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			hold_level_q <= b_level;
			hold_low_q   <= oems_pkg::CHAN_W'(b_pos);
			hold_high_q  <= oems_pkg::CHAN_W'(b_hi);
		end
		if (cmd.load_out) begin
			out_level_q <= hold_level_q;
			out_low_q   <= hold_low_q;
			out_high_q  <= hold_high_q;
			out_last_q  <= wrapped_q;
		end
	end

	assign level           = out_level_q;
	assign low_channel     = out_low_q;
	assign high_channel    = out_high_q;
	assign last_comparator = out_last_q;

endmodule

`default_nettype wire

/* src/oems_checker.sv */
// ----------------------------------------------------------------------------
// oems_checker: port-level checks
// Watches the top level's channels and reports violations.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         cmp_valid,
	input wire logic                         cmp_ready,
	input wire logic [oems_pkg::LEVEL_W-1:0] cmp_level,
	input wire logic [oems_pkg::CHAN_W-1:0]  cmp_low,
	input wire logic [oems_pkg::CHAN_W-1:0]  cmp_high,
	input wire logic                         cmp_last
);

	logic [oems_pkg::CHAN_W-1:0] span;

	assign span = cmp_high - cmp_low;

	// A stalled result holds its payload
	a_cmp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid && !cmp_ready |=> cmp_valid && $stable(cmp_level) && $stable(cmp_low)
			&& $stable(cmp_high) && $stable(cmp_last))
		else $error("comparator payload changed while stalled");

	// One request at a time: ready drops after a request transfer
	a_req_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous one in progress");

	// Comparator spans a power-of-two distance
	a_cmp_span: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid |-> $onehot(span))
		else $error("comparator channel distance is not a power of two");

	// Max channel lies above min channel
	a_cmp_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_valid |-> cmp_high > cmp_low)
		else $error("comparator channels out of order");

endmodule

bind odd_even_merge_comparator_schedule oems_checker u_oems_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.cmp_valid (cmp.valid),
	.cmp_ready (cmp.ready),
	.cmp_level (cmp.level),
	.cmp_low   (cmp.low_channel),
	.cmp_high  (cmp.high_channel),
	.cmp_last  (cmp.last_comparator)
);

`default_nettype wire
